// ===== design/slt_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// slt_pkg
// Shared sizes, request and status codes, and sequencer states for the
// sequential list table.
// ---------------------------------------------------------------------------
package slt_pkg;

    // list capacity and derived widths
    localparam int DEPTH     = 16;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);

    // fixed field widths
    localparam int DATA_W    = 8;
    localparam int REQ_W     = 3;
    localparam int POS_W     = 5;
    localparam int INS_POS_W = 4;
    localparam int STATUS_W  = 2;

    // common width for comparing positions against the length
    localparam int WIDE_A    = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int WIDE_W    = (WIDE_A > INS_POS_W) ? WIDE_A : INS_POS_W;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 3'd0,
        REQ_GET    = 3'd1,
        REQ_LOCATE = 3'd2,
        REQ_DELETE = 3'd3,
        REQ_CLEAR  = 3'd4
    } req_kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK        = 2'd0,
        STS_BAD_POS   = 2'd1,
        STS_NOT_FOUND = 2'd2,
        STS_FULL      = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_WR,
        ST_INS_PUT,
        ST_GET_RD,
        ST_GET_DATA,
        ST_LOC_RD,
        ST_LOC_CMP,
        ST_DEL_RD,
        ST_DEL_WR,
        ST_DEL_END,
        ST_FINISH
    } state_t;

endpackage

// ===== design/slt_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// slt_req_if / slt_rsp_if
// Valid/ready channels for list requests and list responses.
// ---------------------------------------------------------------------------
interface slt_req_if
    import slt_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [REQ_W-1:0]     req_type;
    logic [POS_W-1:0]     position;
    logic [DATA_W-1:0]    value;

    modport source (output valid, output req_type, output position, output value,
                    input ready);
    modport sink   (input valid, input req_type, input position, input value,
                    output ready);
endinterface

interface slt_rsp_if
    import slt_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [DATA_W-1:0]    data_out;
    logic [POS_W-1:0]     found_position;
    logic [POS_W-1:0]     list_length;

    modport source (output valid, output status, output data_out,
                    output found_position, output list_length, input ready);
    modport sink   (input valid, input status, input data_out,
                    input found_position, input list_length, output ready);
endinterface

// ===== design/sequential_list_table.sv =====
`timescale 1ns / 1ps
// One request at a time; each entry moved or compared takes a read step and then
// a write or compare step on the single list RAM.
// Reset clears the length, the insert position and the sequencer; the entry RAM
// is not cleared, entries beyond the length are never read.
// ---------------------------------------------------------------------------
// sequential_list_table
// Fixed-capacity ordered byte list with insert, get, locate, delete and clear,
// run by a small sequencer over one entry RAM.
// ---------------------------------------------------------------------------
module sequential_list_table
    import slt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [INS_POS_W-1:0] cfg_wdata,
    slt_req_if.sink              req,
    slt_rsp_if.source            rsp
);

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [INS_POS_W-1:0]   ins_pos_reg;
    logic                   rsp_valid_reg, rsp_valid_next;

    logic [CNT_W-1:0]       idx_reg, idx_next;
    logic [CNT_W-1:0]       slot_reg, slot_next;
    logic [DATA_W-1:0]      val_reg, val_next;
    status_t                status_reg, status_next;
    logic [DATA_W-1:0]      data_reg, data_next;
    logic [CNT_W-1:0]       found_reg, found_next;

    status_t                status_out_reg, status_out_next;
    logic [DATA_W-1:0]      data_out_reg, data_out_next;
    logic [POS_W-1:0]       found_out_reg, found_out_next;
    logic [POS_W-1:0]       length_out_reg, length_out_next;

    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    logic [DATA_W-1:0]      ram_wdata;
    logic [ADDR_W-1:0]      ram_raddr;
    logic [DATA_W-1:0]      ram_rdata;

    logic                   req_fire;
    logic                   out_free;
    logic [WIDE_W-1:0]      pos_w, cnt_w, ins_w;
    logic                   pos_bad;
    logic                   list_full;
    logic [CNT_W-1:0]       slot_calc;
    logic [CNT_W-1:0]       pos_idx;
    logic [CNT_W-1:0]       idx_dec, idx_inc, idx_inc2;
    logic                   loc_match;

    // entry storage
    slt_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // handshake helpers
    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign out_free  = !rsp_valid_reg || rsp.ready;

    // position checks and index arithmetic
    assign pos_w     = WIDE_W'(req.position);
    assign cnt_w     = WIDE_W'(count_reg);
    assign ins_w     = WIDE_W'(ins_pos_reg);
    assign pos_bad   = (req.position == '0) || (pos_w > cnt_w);
    assign list_full = (count_reg == CNT_W'(DEPTH));
    assign slot_calc = (ins_w > cnt_w) ? count_reg : CNT_W'(ins_pos_reg);
    assign pos_idx   = CNT_W'(pos_w - WIDE_W'(1));
    assign idx_dec   = idx_reg - CNT_W'(1);
    assign idx_inc   = idx_reg + CNT_W'(1);
    assign idx_inc2  = idx_reg + CNT_W'(2);
    assign loc_match = (ram_rdata == val_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    case (req_kind_t'(req.req_type))
                        REQ_INSERT:
                        begin
                            if (list_full)
                                state_next = ST_FINISH;
                            else if (count_reg > slot_calc)
                                state_next = ST_INS_RD;
                            else
                                state_next = ST_INS_PUT;
                        end
                        REQ_GET:
                        begin
                            state_next = pos_bad ? ST_FINISH : ST_GET_RD;
                        end
                        REQ_LOCATE:
                        begin
                            state_next = (count_reg == '0) ? ST_FINISH : ST_LOC_RD;
                        end
                        REQ_DELETE:
                        begin
                            if (pos_bad)
                                state_next = ST_FINISH;
                            else if (pos_w < cnt_w)
                                state_next = ST_DEL_RD;
                            else
                                state_next = ST_DEL_END;
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_INS_RD:   state_next = ST_INS_WR;
            ST_INS_WR:   state_next = (idx_dec > slot_reg) ? ST_INS_RD : ST_INS_PUT;
            ST_INS_PUT:  state_next = ST_FINISH;
            ST_GET_RD:   state_next = ST_GET_DATA;
            ST_GET_DATA: state_next = ST_FINISH;
            ST_LOC_RD:   state_next = ST_LOC_CMP;
            ST_LOC_CMP:
            begin
                if (loc_match || (idx_inc >= count_reg))
                    state_next = ST_FINISH;
                else
                    state_next = ST_LOC_RD;
            end
            ST_DEL_RD:   state_next = ST_DEL_WR;
            ST_DEL_WR:   state_next = (idx_inc2 < count_reg) ? ST_DEL_RD : ST_DEL_END;
            ST_DEL_END:  state_next = ST_FINISH;
            ST_FINISH:   state_next = out_free ? ST_IDLE : ST_FINISH;
            default:     state_next = ST_IDLE;
        endcase
    end

    // datapath, ram control and response word
    always_comb
    begin
        count_next      = count_reg;
        idx_next        = idx_reg;
        slot_next       = slot_reg;
        val_next        = val_reg;
        status_next     = status_reg;
        data_next       = data_reg;
        found_next      = found_reg;
        status_out_next = status_out_reg;
        data_out_next   = data_out_reg;
        found_out_next  = found_out_reg;
        length_out_next = length_out_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg[ADDR_W-1:0];
        ram_wdata       = ram_rdata;
        ram_raddr       = idx_reg[ADDR_W-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    val_next    = req.value;
                    status_next = STS_OK;
                    data_next   = '0;
                    found_next  = '0;
                    case (req_kind_t'(req.req_type))
                        REQ_INSERT:
                        begin
                            idx_next  = count_reg;
                            slot_next = slot_calc;
                            if (list_full)
                                status_next = STS_FULL;
                        end
                        REQ_GET:
                        begin
                            idx_next = pos_idx;
                            if (pos_bad)
                                status_next = STS_BAD_POS;
                        end
                        REQ_LOCATE:
                        begin
                            idx_next    = '0;
                            status_next = STS_NOT_FOUND;
                        end
                        REQ_DELETE:
                        begin
                            idx_next = pos_idx;
                            if (pos_bad)
                                status_next = STS_BAD_POS;
                        end
                        REQ_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            status_next = STS_OK;
                        end
                    endcase
                end
            end
            // shift one entry up: read below, write at idx
            ST_INS_RD:
            begin
                ram_raddr = idx_dec[ADDR_W-1:0];
            end
            ST_INS_WR:
            begin
                ram_we   = 1'b1;
                idx_next = idx_dec;
            end
            ST_INS_PUT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = slot_reg[ADDR_W-1:0];
                ram_wdata  = val_reg;
                count_next = count_reg + CNT_W'(1);
            end
            ST_GET_DATA:
            begin
                data_next = ram_rdata;
            end
            // linear search: read an entry, then compare it
            ST_LOC_CMP:
            begin
                if (loc_match)
                begin
                    found_next  = idx_inc;
                    status_next = STS_OK;
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end
            // close the gap: read above, write at idx
            ST_DEL_RD:
            begin
                ram_raddr = idx_inc[ADDR_W-1:0];
            end
            ST_DEL_WR:
            begin
                ram_we   = 1'b1;
                idx_next = idx_inc;
            end
            ST_DEL_END:
            begin
                count_next = count_reg - CNT_W'(1);
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    rsp_valid_next  = 1'b1;
                    status_out_next = status_reg;
                    data_out_next   = data_reg;
                    found_out_next  = POS_W'(found_reg);
                    length_out_next = POS_W'(count_reg);
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            ins_pos_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                ins_pos_reg <= cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        slot_reg       <= slot_next;
        val_reg        <= val_next;
        status_reg     <= status_next;
        data_reg       <= data_next;
        found_reg      <= found_next;
        status_out_reg <= status_out_next;
        data_out_reg   <= data_out_next;
        found_out_reg  <= found_out_next;
        length_out_reg <= length_out_next;
    end

    // response word
    assign rsp.valid          = rsp_valid_reg;
    assign rsp.status         = status_out_reg;
    assign rsp.data_out       = data_out_reg;
    assign rsp.found_position = found_out_reg;
    assign rsp.list_length    = length_out_reg;

`ifndef SYNTH
    // length never exceeds capacity
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("list length above capacity");

    // an accepted request always starts the sequencer
    a_req_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> (state_reg != ST_IDLE))
        else $error("request accepted without leaving idle");

    // writes stay within the live part of the list plus the new slot
    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (CNT_W'(ram_waddr) <= count_reg))
        else $error("entry write beyond list length");

    // a pending response word is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && rsp_valid_reg && !rsp.ready) |=>
            (state_reg == ST_FINISH))
        else $error("finish left while response still pending");
`endif

endmodule

// ===== design/slt_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// slt_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ---------------------------------------------------------------------------
module slt_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rd_data_reg <= mem_reg[raddr];
    end

    assign rdata = rd_data_reg;

endmodule
